FILE: hdl/gbt_pkg.sv
// Shared types, codes and defaults for the graph traversal engine.
`default_nettype none
package gbt_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam int VTX_W            = 6;
  localparam int CFG_W            = 7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BFS   = 2'd2,
    OP_DFS   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t              cmd;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dest_vertex;
    logic [VTX_W-1:0] start_vertex;
  } req_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    status_t          status;
    logic             last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_WR,
    S_BFS_POP,
    S_BFS_V,
    S_BFS_H,
    S_BFS_E,
    S_DFS_PUSH,
    S_DFS_TOP,
    S_DFS_T2,
    S_DFS_E,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    H_SRC,
    H_START,
    H_WLQ,
    H_DEST
  } hsel_t;

  typedef enum logic [1:0] {
    ES_HD,
    ES_NEXT,
    ES_TOP
  } esel_t;

  typedef enum logic {
    WR_HEAD,
    WR_TOP
  } wrsel_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    add_write;
    logic    bfs_init;
    logic    dfs_init;
    logic    head_rd;
    hsel_t   hsel;
    logic    edge_rd;
    esel_t   esel;
    logic    wl_rd;
    wrsel_t  wrsel;
    logic    bfs_pop;
    logic    bfs_vtx;
    logic    bfs_edge;
    logic    dfs_push;
    logic    dfs_pop;
    logic    dfs_hold;
    logic    dfs_edge;
    logic    emit;
    logic    emit_pend;
    status_t emit_status;
    logic    emit_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic add_bad;
    logic full;
    logic start_bad;
    logic q_empty;
    logic stk_empty;
    logic hd_null;
    logic top_null;
    logic next_null;
    logic edge_take;
    logic have_pend;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hdl/gbt_datapath.sv
// Datapath: edge store, list heads, visited marks, work list and result register.
`default_nettype none
module gbt_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [gbt_pkg::CFG_W-1:0] cfg_wdata,
  input  wire gbt_pkg::req_t           req,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output gbt_pkg::rsp_t                rsp,
  input  wire gbt_pkg::ctl_t           ctl,
  output gbt_pkg::stat_t               stat
);
  import gbt_pkg::*;

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int TW  = $clog2(MAX_VERTICES + 1);
  localparam int WLW = VW + EW;
  localparam logic [EW-1:0]    NIL   = EW'(MAX_EDGES);
  localparam logic [CFG_W-1:0] VMAX  = CFG_W'(MAX_VERTICES);

  logic [CFG_W-1:0] vcount;
  logic [CFG_W-1:0] cnt;
  op_t              op;
  logic [VTX_W-1:0] src, dst, start;
  logic [EW-1:0]    used;

  logic [EW-1:0]    head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] hvalid;
  logic [EW-1:0]    hd_q;
  logic             hd_vq;
  logic [EW-1:0]    hd;
  logic [VW-1:0]    haddr;

  logic [VW-1:0]    dest_mem [MAX_EDGES];
  logic [EW-1:0]    next_mem [MAX_EDGES];
  logic [VW-1:0]    ed_dest;
  logic [EW-1:0]    ed_next;
  logic [EAW-1:0]   eaddr;

  logic [WLW-1:0]   wl_mem [MAX_VERTICES];
  logic [WLW-1:0]   wl_q;
  logic [TW-1:0]    whead, wtail, wtail_m1;
  logic [VW-1:0]    wl_raddr, wl_waddr;
  logic [WLW-1:0]   wl_wdata;
  logic             wl_we;

  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]    pend, push_v, top_v;
  logic             have_pend;
  logic             take;
  logic             out_free;

  // clamp the vertex count into range
  always_comb begin
    if (vcount == '0) cnt = CFG_W'(1);
    else if (vcount > VMAX) cnt = VMAX;
    else cnt = vcount;
  end

  assign hd       = hd_vq ? hd_q : NIL;
  assign wtail_m1 = TW'(wtail - 1'b1);
  assign take     = (CFG_W'(ed_dest) < cnt) && !visited[ed_dest];
  assign out_free = !rsp_valid || !rsp_stall;

  // status toward the controller
  always_comb begin
    stat.op        = op;
    stat.add_bad   = ({1'b0, src} >= cnt) || ({1'b0, dst} >= cnt);
    stat.full      = (used == NIL);
    stat.start_bad = ({1'b0, start} >= cnt);
    stat.q_empty   = (whead == wtail);
    stat.stk_empty = (wtail == '0);
    stat.hd_null   = (hd == NIL);
    stat.top_null  = (wl_q[WLW-1:VW] == NIL);
    stat.next_null = (ed_next == NIL);
    stat.edge_take = take;
    stat.have_pend = have_pend;
    stat.out_free  = out_free;
  end

  // select memory addresses
  always_comb begin
    unique case (ctl.hsel)
      H_SRC:   haddr = src[VW-1:0];
      H_START: haddr = start[VW-1:0];
      H_WLQ:   haddr = wl_q[VW-1:0];
      H_DEST:  haddr = ed_dest;
      default: haddr = src[VW-1:0];
    endcase
    unique case (ctl.esel)
      ES_HD:   eaddr = hd[EAW-1:0];
      ES_NEXT: eaddr = ed_next[EAW-1:0];
      ES_TOP:  eaddr = wl_q[VW+EAW-1:VW];
      default: eaddr = hd[EAW-1:0];
    endcase
    wl_raddr = (ctl.wrsel == WR_HEAD) ? whead[VW-1:0] : wtail_m1[VW-1:0];
  end

  // work list write port
  always_comb begin
    wl_we    = 1'b0;
    wl_waddr = wtail[VW-1:0];
    wl_wdata = {NIL, start[VW-1:0]};
    if (ctl.bfs_init) begin
      wl_we    = 1'b1;
      wl_waddr = '0;
    end else if (ctl.bfs_edge && take) begin
      wl_we    = 1'b1;
      wl_wdata = {NIL, ed_dest};
    end else if (ctl.dfs_push) begin
      wl_we    = 1'b1;
      wl_wdata = {hd, push_v};
    end else if (ctl.dfs_edge) begin
      wl_we    = 1'b1;
      wl_waddr = wtail_m1[VW-1:0];
      wl_wdata = {ed_next, top_v};
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (ctl.head_rd) begin
      hd_q  <= head_mem[haddr];
      hd_vq <= hvalid[haddr];
    end
    if (ctl.add_write) head_mem[src[VW-1:0]] <= used;
  end

  always_ff @(posedge clk) begin
    if (ctl.edge_rd) begin
      ed_dest <= dest_mem[eaddr];
      ed_next <= next_mem[eaddr];
    end
    if (ctl.add_write) begin
      dest_mem[used[EAW-1:0]] <= dst[VW-1:0];
      next_mem[used[EAW-1:0]] <= hd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wl_rd) wl_q <= wl_mem[wl_raddr];
    if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= CFG_W'(MAX_VERTICES_DEF);
      hvalid    <= '0;
      visited   <= '0;
      used      <= '0;
      whead     <= '0;
      wtail     <= '0;
      have_pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) vcount <= cfg_wdata;
      if (ctl.clear) begin
        hvalid  <= '0;
        visited <= '0;
        used    <= '0;
        whead   <= '0;
        wtail   <= '0;
      end
      if (ctl.add_write) begin
        hvalid[src[VW-1:0]] <= 1'b1;
        used <= EW'(used + 1'b1);
      end
      if (ctl.bfs_init) begin
        visited[start[VW-1:0]] <= 1'b1;
        whead     <= '0;
        wtail     <= TW'(1);
        have_pend <= 1'b0;
      end
      if (ctl.dfs_init) begin
        visited[start[VW-1:0]] <= 1'b1;
        wtail     <= '0;
        have_pend <= 1'b1;
      end
      if (ctl.bfs_pop) whead <= TW'(whead + 1'b1);
      if (ctl.bfs_vtx) have_pend <= 1'b1;
      if (ctl.bfs_edge && take) begin
        visited[ed_dest] <= 1'b1;
        wtail <= TW'(wtail + 1'b1);
      end
      if (ctl.dfs_push) wtail <= TW'(wtail + 1'b1);
      if (ctl.dfs_pop) wtail <= wtail_m1;
      if (ctl.dfs_edge && take) visited[ed_dest] <= 1'b1;
      if (ctl.emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op    <= req.cmd;
      src   <= req.src_vertex;
      dst   <= req.dest_vertex;
      start <= req.start_vertex;
    end
    if (ctl.dfs_init) begin
      pend   <= start[VW-1:0];
      push_v <= start[VW-1:0];
    end
    if (ctl.bfs_vtx) pend <= wl_q[VW-1:0];
    if (ctl.dfs_hold) top_v <= wl_q[VW-1:0];
    if (ctl.dfs_edge && take) begin
      pend   <= ed_dest;
      push_v <= ed_dest;
    end
    if (ctl.emit) begin
      rsp.vertex <= ctl.emit_pend ? VTX_W'(pend) : '0;
      rsp.status <= ctl.emit_pend ? ST_OK : ctl.emit_status;
      rsp.last   <= ctl.emit_last;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/gbt_ctrl.sv
// Controller: sequences commands, list walks and result words.
`default_nettype none
module gbt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire gbt_pkg::stat_t stat,
  output gbt_pkg::ctl_t       ctl
);
  import gbt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      // start the command once the result register can take a word
      S_DECODE: begin
        if (stat.out_free) begin
          unique case (stat.op)
            OP_CLEAR: begin
              ctl.clear = 1'b1;
              ctl.emit = 1'b1; ctl.emit_status = ST_OK; ctl.emit_last = 1'b1;
              state_next = S_IDLE;
            end
            OP_ADD: begin
              if (stat.add_bad) begin
                ctl.emit = 1'b1; ctl.emit_status = ST_RANGE; ctl.emit_last = 1'b1;
                state_next = S_IDLE;
              end else if (stat.full) begin
                ctl.emit = 1'b1; ctl.emit_status = ST_FULL; ctl.emit_last = 1'b1;
                state_next = S_IDLE;
              end else begin
                ctl.head_rd = 1'b1; ctl.hsel = H_SRC;
                state_next = S_ADD_WR;
              end
            end
            OP_BFS, OP_DFS: begin
              if (stat.start_bad) begin
                ctl.emit = 1'b1; ctl.emit_status = ST_RANGE; ctl.emit_last = 1'b1;
                state_next = S_IDLE;
              end else if (stat.op == OP_BFS) begin
                ctl.bfs_init = 1'b1;
                state_next = S_BFS_POP;
              end else begin
                ctl.dfs_init = 1'b1;
                ctl.head_rd = 1'b1; ctl.hsel = H_START;
                state_next = S_DFS_PUSH;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_WR: begin
        if (stat.out_free) begin
          ctl.add_write = 1'b1;
          ctl.emit = 1'b1; ctl.emit_status = ST_OK; ctl.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      // breadth-first: dequeue, emit previous, walk the list
      S_BFS_POP: begin
        if (stat.q_empty) begin
          state_next = S_DONE;
        end else begin
          ctl.wl_rd = 1'b1; ctl.wrsel = WR_HEAD;
          ctl.bfs_pop = 1'b1;
          state_next = S_BFS_V;
        end
      end
      S_BFS_V: begin
        if (!stat.have_pend || stat.out_free) begin
          ctl.emit = stat.have_pend; ctl.emit_pend = 1'b1;
          ctl.bfs_vtx = 1'b1;
          ctl.head_rd = 1'b1; ctl.hsel = H_WLQ;
          state_next = S_BFS_H;
        end
      end
      S_BFS_H: begin
        if (stat.hd_null) begin
          state_next = S_BFS_POP;
        end else begin
          ctl.edge_rd = 1'b1; ctl.esel = ES_HD;
          state_next = S_BFS_E;
        end
      end
      S_BFS_E: begin
        ctl.bfs_edge = 1'b1;
        if (stat.next_null) begin
          state_next = S_BFS_POP;
        end else begin
          ctl.edge_rd = 1'b1; ctl.esel = ES_NEXT;
        end
      end
      // depth-first: push, look at top, advance its edge
      S_DFS_PUSH: begin
        ctl.dfs_push = 1'b1;
        state_next = S_DFS_TOP;
      end
      S_DFS_TOP: begin
        if (stat.stk_empty) begin
          state_next = S_DONE;
        end else begin
          ctl.wl_rd = 1'b1; ctl.wrsel = WR_TOP;
          state_next = S_DFS_T2;
        end
      end
      S_DFS_T2: begin
        if (stat.top_null) begin
          ctl.dfs_pop = 1'b1;
          state_next = S_DFS_TOP;
        end else begin
          ctl.dfs_hold = 1'b1;
          ctl.edge_rd = 1'b1; ctl.esel = ES_TOP;
          state_next = S_DFS_E;
        end
      end
      S_DFS_E: begin
        if (stat.edge_take) begin
          if (stat.out_free) begin
            ctl.emit = 1'b1; ctl.emit_pend = 1'b1;
            ctl.dfs_edge = 1'b1;
            ctl.head_rd = 1'b1; ctl.hsel = H_DEST;
            state_next = S_DFS_PUSH;
          end
        end else begin
          ctl.dfs_edge = 1'b1;
          state_next = S_DFS_TOP;
        end
      end
      // flush the held vertex as the final word
      S_DONE: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1; ctl.emit_pend = 1'b1; ctl.emit_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/graph_bfs_dfs_traversal.sv
// Top level of the graph traversal engine.
// Commands: clear, add edge, breadth-first run, depth-first run. Clear and add
// edge each give one word. A run gives one word per reached vertex, the final
// one flagged last; its pace is set by the registered reads of the edge store
// and the work list memory in the walk loop. The next command is taken once the
// previous one has placed its final word in the output register.
`default_nettype none
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = gbt_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gbt_pkg::MAX_EDGES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [gbt_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire gbt_pkg::req_t             req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output gbt_pkg::rsp_t                  rsp
);
  import gbt_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  gbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  gbt_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
`default_nettype wire
